>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/ttm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout table manager package
// Types, codes and sizes shared by the timer table controller and datapath.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {
    ACT_ARM     = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_REFRESH = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_TICK    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ACTIVE    = 2'd2,
    ST_FIRED     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DECIDE,
    S_FIRE,
    S_OUT_FIRE,
    S_OUT_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] delay;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired_valid;
    logic [3:0] fired_id;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic latch_req;
    logic exec_op;
    logic scan_start;
    logic scan_step;
    logic fire;
    logic emit_pend;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic found;
    logic pend;
  } sts_t;

endpackage

>>> rtl/core/ttm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences request execution, deadline scan rounds and result hand-off.
// ----------------------------------------------------------------------------
module ttm_ctrl import ttm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_EXEC;
      S_EXEC:     state_d = sts_i.is_tick ? S_SCAN : S_OUT_DONE;
      S_SCAN:     if (sts_i.scan_last) state_d = S_DECIDE;
      S_DECIDE: begin
        if (sts_i.pend) state_d = sts_i.found ? S_OUT_FIRE : S_OUT_DONE;
        else if (sts_i.found) state_d = S_SCAN;
        else state_d = S_OUT_DONE;
      end
      S_FIRE:     state_d = S_SCAN;
      S_OUT_FIRE: if (!out_stall_i) state_d = S_FIRE;
      S_OUT_DONE: if (!out_stall_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.latch_req = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.scan_start = sts_i.is_tick;
        cmd_o.exec_op    = !sts_i.is_tick;
      end
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_DECIDE: begin
        if (sts_i.pend) begin
          cmd_o.emit_pend = 1'b1;
        end else if (sts_i.found) begin
          cmd_o.fire       = 1'b1;
          cmd_o.scan_start = 1'b1;
        end else begin
          cmd_o.emit_empty = 1'b1;
        end
      end
      S_FIRE: begin
        cmd_o.fire       = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      S_OUT_FIRE: out_valid_o = 1'b1;
      S_OUT_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/ttm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot storage, request execution, deadline scan and result register.
// ----------------------------------------------------------------------------
module ttm_dp import ttm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t out_rsp_o
);

  logic [TIMER_SLOTS-1:0] exists_q, active_q, released_q;
  logic [31:0] delay_q [TIMER_SLOTS];
  logic [63:0] dl_q    [TIMER_SLOTS];
  logic [63:0] ord_q   [TIMER_SLOTS];
  logic [63:0] arm_cnt_q;

  req_t              req_q;
  logic [SLOT_W-1:0] idx_q;
  logic              best_v_q;
  logic [SLOT_W-1:0] best_q;
  logic [63:0]       best_dl_q, best_ord_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pend_id_q;
  rsp_t              out_q;

  logic [SLOT_W-1:0] sel;
  logic              inrange, present, cand, better;
  logic [64:0]       sum;
  logic [63:0]       sched_dl;
  logic [31:0]       sched_delay;
  logic              do_sched;
  logic [1:0]        op_status;

  assign inrange = 32'(req_q.timer_id) < TIMER_SLOTS;
  assign sel     = cmd_i.scan_step ? idx_q : SLOT_W'(req_q.timer_id);
  assign present = inrange && exists_q[sel];

  assign sched_delay = (req_q.action == ACT_ARM) ? req_q.delay : delay_q[sel];
  assign sum         = {1'b0, req_q.now} + 65'(sched_delay);
  assign sched_dl    = sum[64] ? '1 : sum[63:0];

  assign cand   = exists_q[idx_q] && active_q[idx_q] && (dl_q[idx_q] <= req_q.now);
  assign better = !best_v_q || (dl_q[idx_q] < best_dl_q) ||
                  ((dl_q[idx_q] == best_dl_q) && (ord_q[idx_q] < best_ord_q));

  always_comb begin
    do_sched  = 1'b0;
    op_status = ST_OK;
    case (req_q.action)
      ACT_ARM: begin
        if (!inrange) op_status = ST_NOT_FOUND;
        else if (exists_q[sel] && active_q[sel]) op_status = ST_ACTIVE;
        else do_sched = 1'b1;
      end
      ACT_CLEAR, ACT_RELEASE: if (!present) op_status = ST_NOT_FOUND;
      ACT_REFRESH: begin
        if (!present) op_status = ST_NOT_FOUND;
        else do_sched = 1'b1;
      end
      default: op_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q   <= '0;
      active_q   <= '0;
      released_q <= '0;
      arm_cnt_q  <= '0;
      best_v_q   <= 1'b0;
      pend_q     <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.exec_op && do_sched) begin
        active_q[sel] <= 1'b1;
        arm_cnt_q     <= arm_cnt_q + 64'd1;
        if (req_q.action == ACT_ARM) begin
          exists_q[sel]   <= 1'b1;
          released_q[sel] <= 1'b0;
        end
      end
      if (cmd_i.exec_op && present && req_q.action == ACT_CLEAR) begin
        active_q[sel] <= 1'b0;
      end
      if (cmd_i.exec_op && present && req_q.action == ACT_RELEASE) begin
        if (active_q[sel]) begin
          released_q[sel] <= 1'b1;
        end else begin
          exists_q[sel]   <= 1'b0;
          released_q[sel] <= 1'b0;
        end
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (cand && better) best_v_q <= 1'b1;
      end
      if (cmd_i.fire) begin
        active_q[best_q] <= 1'b0;
        if (released_q[best_q]) begin
          exists_q[best_q]   <= 1'b0;
          released_q[best_q] <= 1'b0;
        end
        pend_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q    <= '0;
        best_v_q <= 1'b0;
      end
      if (cmd_i.emit_pend) pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) req_q <= in_req_i;
    if (cmd_i.exec_op && do_sched) begin
      dl_q[sel]  <= sched_dl;
      ord_q[sel] <= arm_cnt_q;
      if (req_q.action == ACT_ARM) delay_q[sel] <= req_q.delay;
    end
    if (cmd_i.scan_step && cand && better) begin
      best_q     <= idx_q;
      best_dl_q  <= dl_q[idx_q];
      best_ord_q <= ord_q[idx_q];
    end
    if (cmd_i.fire) pend_id_q <= best_q;
    if (cmd_i.exec_op) out_q <= '{status: op_status, fired_valid: 1'b0,
                                  fired_id: 4'd0, last: 1'b1};
    if (cmd_i.emit_pend) out_q <= '{status: ST_FIRED, fired_valid: 1'b1,
                                    fired_id: 4'(pend_id_q), last: !best_v_q};
    if (cmd_i.emit_empty) out_q <= '{status: ST_OK, fired_valid: 1'b0,
                                     fired_id: 4'd0, last: 1'b1};
  end

  assign sts_o.is_tick   = (req_q.action == ACT_TICK);
  assign sts_o.scan_last = (32'(idx_q) == TIMER_SLOTS - 1);
  assign sts_o.found     = best_v_q;
  assign sts_o.pend      = pend_q;
  assign out_rsp_o       = out_q;

endmodule

>>> rtl/core/timeout_table_manager_top.sv
`timescale 1ns / 1ps
// Arm, clear, refresh, release: latched in S_IDLE, executed in S_EXEC, result in S_OUT_DONE.
// Tick: scan rounds over all TIMER_SLOTS slots, one slot compared a cycle, each ending in
//   S_DECIDE; the earliest due slot of a round is fired and reported after the next round,
//   and a round that finds nothing due ends the tick.
// Requests: one at a time; the next can be taken in the cycle after the last result is taken.
// Reset: asynchronous, clears all slot flags, the arm counter and the controller.
// ----------------------------------------------------------------------------
// Timeout table manager
// Deadline-ordered one-shot timer table with arm, clear, refresh, release, tick.
// ----------------------------------------------------------------------------
module timeout_table_manager_top import ttm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  ttm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

>>> rtl/core/ttm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table port checker
// Port-level properties of the timeout table manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttm_checker import ttm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  `ASSERT_CLK(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o),
    "result changed while stalled")
  `ASSERT_CLK(a_fired_code,
    out_valid_o |-> ((out_rsp_o.status == ST_FIRED) == out_rsp_o.fired_valid),
    "fired flag and status disagree")
  `ASSERT_CLK(a_plain_last,
    out_valid_o && !out_rsp_o.fired_valid |-> out_rsp_o.last,
    "non-fired result without last")
  `ASSERT_CLK(a_busy_after_req,
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o,
    "request taken while busy")
  `ASSERT_NEVER(a_known_hs, $isunknown({in_stall_o, out_valid_o}),
    "handshake output unknown")

endmodule

bind timeout_table_manager_top ttm_checker u_ttm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
